@@ rtl/xed_pkg.sv @@
`default_nettype none

package xed_pkg;

  // Sizing
  localparam int unsigned MaxEntityDefault = 16;
  // Flush length field in a command; holds any entity length up to 127
  localparam int unsigned LenMaxW          = 7;
  localparam int unsigned QueueDepth       = 2;
  localparam int unsigned NumNames         = 5;

  // Characters
  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChLowX = 8'h78;
  localparam logic [7:0] ChUpX  = 8'h58;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChQuot = 8'h22;
  localparam logic [7:0] ChApos = 8'h27;

  // Named entity indexes
  localparam int unsigned NameAmp  = 0;
  localparam int unsigned NameLt   = 1;
  localparam int unsigned NameGt   = 2;
  localparam int unsigned NameQuot = 3;
  localparam int unsigned NameApos = 4;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Lead4 = 8'hF0;
  localparam logic [7:0] Utf8Cont  = 8'h80;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       run_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } out_item_t;

  typedef enum logic [2:0] {
    ModePass = 3'b001,
    ModeEnt  = 3'b010,
    ModeLong = 3'b100
  } mode_e;

  typedef enum logic [0:0] {
    CmdSeq   = 1'b0,
    CmdFlush = 1'b1
  } cmd_kind_e;

  // One command per transaction that produces output
  typedef struct packed {
    cmd_kind_e            kind;
    logic [3:0][7:0]      bytes;      // sequence bytes; bytes[0] is the flush trailer
    logic [1:0]           last_idx;   // index of the final sequence byte
    logic [LenMaxW-1:0]   flush_len;  // buffered name bytes to replay
    logic                 trail;      // flush ends with bytes[0]
    logic                 run_end;
  } cmd_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } utf8_t;

  typedef struct packed {
    logic               en;
    logic [LenMaxW-1:0] addr;
    logic [7:0]         data;
  } buf_wr_t;

  typedef struct packed {
    logic flush_done;
  } back_status_t;

  // Name characters, byte i at bits [8*i +: 8]
  function automatic logic [31:0] name_word(input int unsigned k);
    logic [31:0] w;
    unique case (k)
      NameAmp:  w = 32'h00_70_6D_61;
      NameLt:   w = 32'h00_00_74_6C;
      NameGt:   w = 32'h00_00_74_67;
      NameQuot: w = 32'h74_6F_75_71;
      NameApos: w = 32'h73_6F_70_61;
      default:  w = '0;
    endcase
    return w;
  endfunction

  // One character of a name
  function automatic logic [7:0] name_char(input int unsigned k, input logic [1:0] i);
    logic [31:0] w;
    w = name_word(k);
    return w[8*i +: 8];
  endfunction

  function automatic logic [2:0] name_size(input int unsigned k);
    logic [2:0] n;
    unique case (k)
      NameAmp:  n = 3'd3;
      NameLt:   n = 3'd2;
      NameGt:   n = 3'd2;
      NameQuot: n = 3'd4;
      NameApos: n = 3'd4;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_byte(input int unsigned k);
    logic [7:0] b;
    unique case (k)
      NameAmp:  b = ChAmp;
      NameLt:   b = ChLt;
      NameGt:   b = ChGt;
      NameQuot: b = ChQuot;
      NameApos: b = ChApos;
      default:  b = '0;
    endcase
    return b;
  endfunction

  // Encode a code point as 1 to 4 UTF-8 bytes
  function automatic utf8_t utf8_encode(input logic [63:0] cp);
    utf8_t r;
    r = '0;
    if (cp[63:7] == '0) begin
      r.bytes[0] = cp[7:0];
      r.last_idx = 2'd0;
    end else if (cp[63:11] == '0) begin
      r.bytes[0] = Utf8Lead2 | {3'b000, cp[10:6]};
      r.bytes[1] = Utf8Cont | {2'b00, cp[5:0]};
      r.last_idx = 2'd1;
    end else if (cp[63:16] == '0) begin
      r.bytes[0] = Utf8Lead3 | {4'b0000, cp[15:12]};
      r.bytes[1] = Utf8Cont | {2'b00, cp[11:6]};
      r.bytes[2] = Utf8Cont | {2'b00, cp[5:0]};
      r.last_idx = 2'd2;
    end else begin
      r.bytes[0] = Utf8Lead4 | cp[25:18];
      r.bytes[1] = Utf8Cont | {2'b00, cp[17:12]};
      r.bytes[2] = Utf8Cont | {2'b00, cp[11:6]};
      r.bytes[3] = Utf8Cont | {2'b00, cp[5:0]};
      r.last_idx = 2'd3;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/xml_entity_decoder_unit.sv @@
// Byte-stream XML entity decoder. Each input transaction carries one byte of a
// text run; output transactions carry decoded bytes, with run_last on the last
// byte caused by an input and text_done on the last byte of the run. Plain
// bytes, named entities and numeric entities (1 to 4 UTF-8 bytes) leave at one
// output byte per cycle while the output is not stalled, through the command
// queue, the back sequencer and its output register, so plain text streams at
// one byte per cycle. The back sequencer emits one byte per cycle unless stalled,
// and a numeric entity gives up to four bytes. A literal replay of an unknown,
// over-long or unterminated entity reads the name buffer through its single read
// port, sending '&', the name and any trailing byte; input stalls until it is done.
`default_nettype none

module xml_entity_decoder_unit #(
  parameter int unsigned MaxEntity = xed_pkg::MaxEntityDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire xed_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output xed_pkg::out_item_t      out_data_o
);

  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  empty;
  xed_pkg::cmd_t         cmd_in;
  xed_pkg::cmd_t         cmd_out;
  xed_pkg::buf_wr_t      buf_wr;
  xed_pkg::back_status_t back_status;

  // Accept and classify bytes
  xed_front #(
    .MaxEntity (MaxEntity)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .full_i     (full),
    .wr_o       (buf_wr),
    .status_i   (back_status)
  );

  // Decouple front and back
  xed_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  // Emit output bytes
  xed_back #(
    .MaxEntity (MaxEntity)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .wr_i        (buf_wr),
    .status_o    (back_status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/xed_front.sv @@
`default_nettype none

module xed_front #(
  parameter int unsigned MaxEntity = xed_pkg::MaxEntityDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire xed_pkg::in_item_t    in_data_i,
  output logic                      push_o,
  output xed_pkg::cmd_t             cmd_o,
  input  wire logic                 full_i,
  output xed_pkg::buf_wr_t          wr_o,
  input  wire xed_pkg::back_status_t status_i
);

  localparam int unsigned LenW = $clog2(MaxEntity + 1);

  xed_pkg::mode_e                   mode_q, mode_d;
  logic [LenW-1:0]                  len_q, len_d;
  logic [63:0]                      dec_q, dec_d;
  logic [63:0]                      hex_q, hex_d;
  logic [xed_pkg::NumNames-1:0]     nm_q, nm_d;
  logic                             hash_q, hash_d;
  logic                             hexform_q, hexform_d;
  logic                             hold_q, hold_d;

  logic                             accept;
  logic [7:0]                       c;
  logic                             endr;
  logic [xed_pkg::NumNames-1:0]     hit;
  logic [7:0]                       rep;
  logic [3:0]                       dv;
  xed_pkg::utf8_t                   enc;

  // Stall while the queue is full or a literal flush still reads the buffer
  assign in_stall_o = full_i || hold_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign c          = in_data_i.in_byte;
  assign endr       = in_data_i.run_end;

  // Match named entities and pick the replacement byte
  always_comb begin
    rep = '0;
    for (int k = 0; k < xed_pkg::NumNames; k++) begin
      hit[k] = nm_q[k] && (len_q == LenW'(xed_pkg::name_size(k)));
      if (hit[k]) begin
        rep = xed_pkg::name_byte(k);
      end
    end
  end

  // Hex digit value; anything else adds nothing
  always_comb begin
    if (c >= 8'h30 && c <= 8'h39) begin
      dv = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      dv = 4'(c[3:0] + 4'd9);
    end else begin
      dv = 4'd0;
    end
  end

  assign enc = xed_pkg::utf8_encode(hexform_q ? hex_q : dec_q);

  // Classify each transaction and issue at most one command
  always_comb begin
    mode_d    = mode_q;
    len_d     = len_q;
    dec_d     = dec_q;
    hex_d     = hex_q;
    nm_d      = nm_q;
    hash_d    = hash_q;
    hexform_d = hexform_q;
    hold_d    = hold_q;
    push_o    = 1'b0;
    cmd_o     = '0;
    cmd_o.run_end = endr;
    wr_o      = '0;

    if (status_i.flush_done) begin
      hold_d = 1'b0;
    end

    if (accept) begin
      unique case (mode_q)
        xed_pkg::ModeEnt: begin
          if (c == xed_pkg::ChSemi) begin
            mode_d = xed_pkg::ModePass;
            push_o = 1'b1;
            if (|hit) begin
              cmd_o.kind     = xed_pkg::CmdSeq;
              cmd_o.bytes[0] = rep;
            end else if (len_q > LenW'(1) && hash_q) begin
              cmd_o.kind     = xed_pkg::CmdSeq;
              cmd_o.bytes    = enc.bytes;
              cmd_o.last_idx = enc.last_idx;
            end else begin
              cmd_o.kind      = xed_pkg::CmdFlush;
              cmd_o.flush_len = xed_pkg::LenMaxW'(len_q);
              cmd_o.trail     = 1'b1;
              cmd_o.bytes[0]  = xed_pkg::ChSemi;
            end
          end else if (len_q >= LenW'(MaxEntity)) begin
            // Over-long name: replay it and the current byte, then copy
            mode_d          = xed_pkg::ModeLong;
            push_o          = 1'b1;
            cmd_o.kind      = xed_pkg::CmdFlush;
            cmd_o.flush_len = xed_pkg::LenMaxW'(len_q);
            cmd_o.trail     = 1'b1;
            cmd_o.bytes[0]  = c;
          end else begin
            // Absorb the byte into the name
            if (len_q != '0) begin
              dec_d = (dec_q << 3) + (dec_q << 1) + {{56{c[7]}}, c}
                      - {56'd0, xed_pkg::ChZero};
            end
            if (len_q >= LenW'(2)) begin
              hex_d = {hex_q[59:0], dv};
            end
            if (len_q == '0) begin
              hash_d = (c == xed_pkg::ChHash);
            end
            if (len_q == LenW'(1)) begin
              hexform_d = (c == xed_pkg::ChLowX) || (c == xed_pkg::ChUpX);
            end
            for (int k = 0; k < xed_pkg::NumNames; k++) begin
              nm_d[k] = nm_q[k] && (len_q < LenW'(xed_pkg::name_size(k)))
                        && (c == xed_pkg::name_char(k, len_q[1:0]));
            end
            wr_o.en   = 1'b1;
            wr_o.addr = xed_pkg::LenMaxW'(len_q);
            wr_o.data = c;
            len_d     = LenW'(len_q + LenW'(1));
            if (endr) begin
              push_o          = 1'b1;
              cmd_o.kind      = xed_pkg::CmdFlush;
              cmd_o.flush_len = xed_pkg::LenMaxW'(len_q + LenW'(1));
            end
          end
        end
        xed_pkg::ModeLong: begin
          push_o         = 1'b1;
          cmd_o.kind     = xed_pkg::CmdSeq;
          cmd_o.bytes[0] = c;
          if (c == xed_pkg::ChSemi) begin
            mode_d = xed_pkg::ModePass;
          end
        end
        default: begin
          // Pass-through
          if (c == xed_pkg::ChAmp) begin
            mode_d = xed_pkg::ModeEnt;
            len_d  = '0;
            dec_d  = '0;
            hex_d  = '0;
            nm_d   = '1;
            if (endr) begin
              push_o         = 1'b1;
              cmd_o.kind     = xed_pkg::CmdSeq;
              cmd_o.bytes[0] = xed_pkg::ChAmp;
            end
          end else begin
            push_o         = 1'b1;
            cmd_o.kind     = xed_pkg::CmdSeq;
            cmd_o.bytes[0] = c;
          end
        end
      endcase

      if (endr) begin
        mode_d = xed_pkg::ModePass;
      end
      if (push_o && cmd_o.kind == xed_pkg::CmdFlush) begin
        hold_d = 1'b1;
      end
    end
  end

  // Hold the entity state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= xed_pkg::ModePass;
      len_q     <= '0;
      dec_q     <= '0;
      hex_q     <= '0;
      nm_q      <= '0;
      hash_q    <= 1'b0;
      hexform_q <= 1'b0;
      hold_q    <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      len_q     <= len_d;
      dec_q     <= dec_d;
      hex_q     <= hex_d;
      nm_q      <= nm_d;
      hash_q    <= hash_d;
      hexform_q <= hexform_d;
      hold_q    <= hold_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/xed_cmd_queue.sv @@
`default_nettype none

module xed_cmd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire xed_pkg::cmd_t cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output xed_pkg::cmd_t      cmd_o
);

  localparam int unsigned PtrW = $clog2(xed_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(xed_pkg::QueueDepth + 1);

  xed_pkg::cmd_t   entries_q [xed_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(xed_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(xed_pkg::QueueDepth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(xed_pkg::QueueDepth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/xed_back.sv @@
`default_nettype none

module xed_back #(
  parameter int unsigned MaxEntity = xed_pkg::MaxEntityDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              empty_i,
  input  wire xed_pkg::cmd_t     cmd_i,
  output logic                   pop_o,
  input  wire xed_pkg::buf_wr_t  wr_i,
  output xed_pkg::back_status_t  status_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output xed_pkg::out_item_t     out_data_o
);

  localparam int unsigned AddrW = $clog2(MaxEntity);
  localparam int unsigned IdxW  = $clog2(MaxEntity + 2);

  logic [7:0]          name_mem [MaxEntity];
  logic [7:0]          rd_q;
  logic [AddrW-1:0]    rd_addr;

  logic                busy_q, busy_d;
  xed_pkg::cmd_t       cmd_q, cmd_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  xed_pkg::out_item_t  out_q, out_d;

  logic                fire;
  logic                last;
  logic [7:0]          step_byte;
  logic [IdxW-1:0]     flen;

  assign flen = IdxW'(cmd_q.flush_len);
  assign fire = busy_q && (!out_valid_q || !out_stall_i);

  // Pick the byte of the current step
  always_comb begin
    if (cmd_q.kind == xed_pkg::CmdSeq) begin
      step_byte = cmd_q.bytes[idx_q[1:0]];
      last      = (idx_q == IdxW'(cmd_q.last_idx));
    end else begin
      if (idx_q == '0) begin
        step_byte = xed_pkg::ChAmp;
      end else if (idx_q <= flen) begin
        step_byte = rd_q;
      end else begin
        step_byte = cmd_q.bytes[0];
      end
      last = (idx_q == IdxW'(flen + IdxW'(cmd_q.trail)));
    end
  end

  // Sequence the steps and load the next command when idle or on the final step
  always_comb begin
    busy_d      = busy_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = !empty_i && (!busy_q || (fire && last));

    if (fire) begin
      idx_d           = IdxW'(idx_q + 1'b1);
      out_valid_d     = 1'b1;
      out_d.out_byte  = step_byte;
      out_d.run_last  = last;
      out_d.text_done = last && cmd_q.run_end;
      if (last) begin
        busy_d = 1'b0;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (pop_o) begin
      busy_d = 1'b1;
      cmd_d  = cmd_i;
      idx_d  = '0;
    end
  end

  assign status_o.flush_done = fire && last && (cmd_q.kind == xed_pkg::CmdFlush);

  // Read ahead so the name byte for the next step is ready
  assign rd_addr = (idx_d == '0) ? '0 : AddrW'(idx_d - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  // Name buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      name_mem[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
    rd_q <= name_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/xed_checker.sv @@
`default_nettype none

module xed_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire xed_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire xed_pkg::out_item_t out_data_o
);

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // End of run only on the last byte of an input
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.text_done |-> out_data_o.run_last)
    else $error("text_done without run_last");

  // Nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("output valid straight after reset");

  // Hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input transaction changed while stalled");

endmodule

bind xml_entity_decoder_unit xed_checker u_xed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

@@ tb/xml_entity_decoder_unit_tb.sv @@
`timescale 1ns / 1ps

module xml_entity_decoder_unit_tb;

  localparam int unsigned NameDepth      = xed_pkg::MaxEntityDefault;
  localparam int unsigned NumDirected    = 25;
  localparam int unsigned RandomItems    = 400;
  localparam int unsigned LongHoldAt     = 150;
  localparam int unsigned LongHoldCycles = 120;
  localparam int unsigned MidPauseAt     = 300;
  localparam int unsigned QuietTail      = 60;
  localparam int unsigned DrainCycles    = 40;
  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned MaxReported    = 10;

  // One stimulus transaction; typed rows carry their own expected bytes
  typedef struct packed {
    xed_pkg::in_item_t item;
    logic              typed;
    logic [2:0]        n_typed;
    logic [31:0]       typed_bytes;  // byte k at [8*k +: 8]
  } stim_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  xed_pkg::in_item_t  in_data_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  xed_pkg::out_item_t out_data_o;

  xml_entity_decoder_unit #(
    .MaxEntity(NameDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Stimulus and bookkeeping
  stim_row_t          directed_tbl [NumDirected];
  stim_row_t          stim_rows [$];
  xed_pkg::out_item_t decoded_q [$];
  int unsigned        rows_taken = 0;
  int unsigned        fail_cnt = 0;
  bit                 idle_off = 1'b0;

  // Decoder state as the testbench sees it
  xed_pkg::mode_e     dec_mode = xed_pkg::ModePass;
  logic [7:0]         name_buf [NameDepth];
  int unsigned        name_cnt = 0;
  logic [63:0]        dec_acc = '0;
  logic [63:0]        hex_acc = '0;
  logic [7:0]         step_bytes [$];

  string named_ents [5] = '{"amp", "lt", "gt", "quot", "apos"};
  string hex_chars = "0123456789abcdefABCDEF";

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic stim_row_t plain_row(input logic [7:0] b, input logic e);
    stim_row_t r;
    r = '0;
    r.item.in_byte = b;
    r.item.run_end = e;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [7:0] b, input logic e,
                                            input logic [2:0] n, input logic [31:0] w);
    stim_row_t r;
    r = plain_row(b, e);
    r.typed       = 1'b1;
    r.n_typed     = n;
    r.typed_bytes = w;
    return r;
  endfunction

  function automatic bit name_matches(input string s);
    if (name_cnt != s.len()) return 1'b0;
    for (int k = 0; k < s.len(); k++) begin
      if (name_buf[k] != s[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Copy '&' and the buffered name out literally
  task automatic replay_name();
    step_bytes.push_back(xed_pkg::ChAmp);
    for (int k = 0; k < name_cnt; k++) step_bytes.push_back(name_buf[k]);
  endtask

  // Work out the bytes one input transaction causes and advance the state
  task automatic decode_byte(input xed_pkg::in_item_t it);
    logic [7:0]  c;
    logic [63:0] cp;
    logic [63:0] digit;
    c = it.in_byte;
    step_bytes.delete();
    case (dec_mode)
      xed_pkg::ModeEnt: begin
        if (c == xed_pkg::ChSemi) begin
          if (name_matches("amp")) step_bytes.push_back(xed_pkg::ChAmp);
          else if (name_matches("lt")) step_bytes.push_back(xed_pkg::ChLt);
          else if (name_matches("gt")) step_bytes.push_back(xed_pkg::ChGt);
          else if (name_matches("quot")) step_bytes.push_back(xed_pkg::ChQuot);
          else if (name_matches("apos")) step_bytes.push_back(xed_pkg::ChApos);
          else if (name_cnt > 1 && name_buf[0] == xed_pkg::ChHash) begin
            cp = (name_buf[1] == xed_pkg::ChLowX || name_buf[1] == xed_pkg::ChUpX)
                 ? hex_acc : dec_acc;
            if (cp < 64'h80) begin
              step_bytes.push_back(cp[7:0]);
            end else if (cp < 64'h800) begin
              step_bytes.push_back(xed_pkg::Utf8Lead2 | {3'b000, cp[10:6]});
              step_bytes.push_back(xed_pkg::Utf8Cont | {2'b00, cp[5:0]});
            end else if (cp < 64'h10000) begin
              step_bytes.push_back(xed_pkg::Utf8Lead3 | {4'b0000, cp[15:12]});
              step_bytes.push_back(xed_pkg::Utf8Cont | {2'b00, cp[11:6]});
              step_bytes.push_back(xed_pkg::Utf8Cont | {2'b00, cp[5:0]});
            end else begin
              step_bytes.push_back(xed_pkg::Utf8Lead4 | cp[25:18]);
              step_bytes.push_back(xed_pkg::Utf8Cont | {2'b00, cp[17:12]});
              step_bytes.push_back(xed_pkg::Utf8Cont | {2'b00, cp[11:6]});
              step_bytes.push_back(xed_pkg::Utf8Cont | {2'b00, cp[5:0]});
            end
          end else begin
            replay_name();
            step_bytes.push_back(xed_pkg::ChSemi);
          end
          dec_mode = xed_pkg::ModePass;
        end else if (name_cnt >= NameDepth) begin
          // over-long name: flush and pass through up to the next ';'
          replay_name();
          step_bytes.push_back(c);
          dec_mode = xed_pkg::ModeLong;
        end else begin
          // accumulate both numeric readings, wrapping at 64 bits
          if (name_cnt >= 1) begin
            dec_acc = dec_acc * 64'd10 + {{56{c[7]}}, c} - {56'd0, xed_pkg::ChZero};
          end
          if (name_cnt >= 2) begin
            digit = '0;
            if (c >= "0" && c <= "9") digit = c - "0";
            else if (c >= "a" && c <= "f") digit = c - "a" + 10;
            else if (c >= "A" && c <= "F") digit = c - "A" + 10;
            hex_acc = (hex_acc << 4) + digit;
          end
          name_buf[name_cnt] = c;
          name_cnt++;
          if (it.run_end) replay_name();
        end
      end
      xed_pkg::ModeLong: begin
        step_bytes.push_back(c);
        if (c == xed_pkg::ChSemi) dec_mode = xed_pkg::ModePass;
      end
      default: begin
        if (c == xed_pkg::ChAmp) begin
          dec_mode = xed_pkg::ModeEnt;
          name_cnt = 0;
          dec_acc  = '0;
          hex_acc  = '0;
          if (it.run_end) step_bytes.push_back(xed_pkg::ChAmp);
        end else begin
          step_bytes.push_back(c);
        end
      end
    endcase
    if (it.run_end) dec_mode = xed_pkg::ModePass;
  endtask

  task automatic report_fail(input string what, input xed_pkg::out_item_t want,
                             input xed_pkg::out_item_t got);
    fail_cnt++;
    if (fail_cnt <= MaxReported) begin
      $display("%s: want byte %02h last %0d done %0d, got byte %02h last %0d done %0d",
               what, want.out_byte, want.run_last, want.text_done,
               got.out_byte, got.run_last, got.text_done);
    end
  endtask

  function automatic logic [7:0] not_semi();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == xed_pkg::ChSemi);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return xed_pkg::ChAmp;
      1:       return xed_pkg::ChSemi;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    stim_rows.push_back(plain_row(b, 1'b0));
  endtask

  // Append one random run: mostly well-formed entities, some noise and breakage
  task automatic add_random_run();
    string       nm;
    int unsigned n;
    case ($urandom_range(0, 11))
      0, 1: begin
        repeat ($urandom_range(1, 6)) begin
          stim_rows.push_back(plain_row(noise_byte(), $urandom_range(0, 19) == 0));
        end
      end
      2, 3, 4: begin
        nm = named_ents[$urandom_range(0, 4)];
        add_byte(xed_pkg::ChAmp);
        for (int k = 0; k < nm.len(); k++) add_byte(nm[k]);
        add_byte(xed_pkg::ChSemi);
      end
      5: begin
        add_byte(xed_pkg::ChAmp);
        add_byte(xed_pkg::ChHash);
        n = ($urandom_range(0, 3) == 0) ? 14 : 7;
        repeat ($urandom_range(1, n)) add_byte(8'("0" + $urandom_range(0, 9)));
        add_byte(xed_pkg::ChSemi);
      end
      6: begin
        add_byte(xed_pkg::ChAmp);
        add_byte(xed_pkg::ChHash);
        add_byte($urandom_range(0, 1) ? xed_pkg::ChLowX : xed_pkg::ChUpX);
        repeat ($urandom_range(0, 14)) add_byte(hex_chars[$urandom_range(0, 21)]);
        add_byte(xed_pkg::ChSemi);
      end
      7: begin
        add_byte(xed_pkg::ChAmp);
        repeat ($urandom_range(0, NameDepth)) add_byte(not_semi());
        add_byte(xed_pkg::ChSemi);
      end
      8: begin
        add_byte(xed_pkg::ChAmp);
        repeat ($urandom_range(NameDepth + 1, NameDepth + 4)) add_byte(not_semi());
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
        add_byte(xed_pkg::ChSemi);
      end
      9: begin
        add_byte(xed_pkg::ChAmp);
        add_byte(xed_pkg::ChHash);
        repeat ($urandom_range(1, NameDepth - 1)) add_byte(not_semi());
        add_byte(xed_pkg::ChSemi);
      end
      10: begin
        add_byte(xed_pkg::ChAmp);
        repeat ($urandom_range(0, NameDepth - 1)) add_byte(not_semi());
        stim_rows[stim_rows.size() - 1].item.run_end = 1'b1;
      end
      default: begin
        // near miss of a known name
        nm = named_ents[$urandom_range(0, 4)];
        add_byte(xed_pkg::ChAmp);
        for (int k = 0; k < nm.len() - 1; k++) add_byte(nm[k]);
        if ($urandom_range(0, 1)) add_byte(not_semi());
        add_byte(xed_pkg::ChSemi);
      end
    endcase
    if ($urandom_range(0, 7) == 0) stim_rows[stim_rows.size() - 1].item.run_end = 1'b1;
  endtask

  // Predict on every input transaction, check every output transaction
  always @(posedge clk_i) begin
    stim_row_t          row;
    xed_pkg::out_item_t want;
    xed_pkg::out_item_t got;
    int unsigned        n;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_data_i);
        row = stim_rows[rows_taken];
        if (row.typed) begin
          step_bytes.delete();
          for (int k = 0; k < row.n_typed; k++) step_bytes.push_back(row.typed_bytes[8*k +: 8]);
        end
        n = step_bytes.size();
        for (int k = 0; k < n; k++) begin
          want.out_byte  = step_bytes[k];
          want.run_last  = (k == n - 1);
          want.text_done = (k == n - 1) && in_data_i.run_end;
          decoded_q.push_back(want);
        end
        rows_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        if (decoded_q.size() == 0) begin
          report_fail("unexpected output", '0, got);
        end else begin
          want = decoded_q.pop_front();
          if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
              got.text_done !== want.text_done) begin
            report_fail("mismatch", want, got);
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off to fill the block
  initial begin
    int unsigned stall_left;
    bit          long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && rows_taken >= LongHoldAt) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(posedge clk_i);
      end
      if (stall_left != 0) stall_left--;
      else if (!idle_off && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 11);
      out_stall_i <= (stall_left != 0);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin
    int unsigned still_cycles;
    still_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
        still_cycles = 0;
      end else begin
        still_cycles++;
      end
      if (still_cycles >= WatchdogLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Sender: reset, build the stimulus, drive it, then drain and judge
  initial begin
    int unsigned gap;
    directed_tbl = '{
      // extremes of the byte, the second one ending a run
      checked_row(8'h00, 1'b0, 3'd1, 32'h0000_0000),
      checked_row(8'hFF, 1'b1, 3'd1, 32'h0000_00FF),
      // named entity
      checked_row(xed_pkg::ChAmp, 1'b0, 3'd0, '0),
      checked_row("l", 1'b0, 3'd0, '0),
      checked_row("t", 1'b0, 3'd0, '0),
      checked_row(xed_pkg::ChSemi, 1'b0, 3'd1, {24'h0, xed_pkg::ChLt}),
      // empty entity copied literally
      checked_row(xed_pkg::ChAmp, 1'b0, 3'd0, '0),
      checked_row(xed_pkg::ChSemi, 1'b0, 3'd2,
                  {16'h0, xed_pkg::ChSemi, xed_pkg::ChAmp}),
      // lone hash is unknown
      checked_row(xed_pkg::ChAmp, 1'b0, 3'd0, '0),
      checked_row(xed_pkg::ChHash, 1'b0, 3'd0, '0),
      checked_row(xed_pkg::ChSemi, 1'b0, 3'd3,
                  {8'h0, xed_pkg::ChSemi, xed_pkg::ChHash, xed_pkg::ChAmp}),
      // hex form with no digits gives a zero byte
      checked_row(xed_pkg::ChAmp, 1'b0, 3'd0, '0),
      checked_row(xed_pkg::ChHash, 1'b0, 3'd0, '0),
      checked_row(xed_pkg::ChLowX, 1'b0, 3'd0, '0),
      checked_row(xed_pkg::ChSemi, 1'b0, 3'd1, 32'h0),
      // entity still open at the end of the run
      checked_row(xed_pkg::ChAmp, 1'b0, 3'd0, '0),
      checked_row(xed_pkg::ChHash, 1'b1, 3'd2,
                  {16'h0, xed_pkg::ChHash, xed_pkg::ChAmp}),
      checked_row(xed_pkg::ChAmp, 1'b1, 3'd1, {24'h0, xed_pkg::ChAmp}),
      // '&' inside an entity is a plain name byte
      checked_row(xed_pkg::ChAmp, 1'b0, 3'd0, '0),
      checked_row(xed_pkg::ChAmp, 1'b0, 3'd0, '0),
      checked_row(xed_pkg::ChSemi, 1'b0, 3'd3,
                  {8'h0, xed_pkg::ChSemi, xed_pkg::ChAmp, xed_pkg::ChAmp}),
      plain_row(xed_pkg::ChAmp, 1'b0),
      plain_row("g", 1'b0),
      plain_row("t", 1'b0),
      plain_row(xed_pkg::ChSemi, 1'b0)
    };
    foreach (directed_tbl[k]) stim_rows.push_back(directed_tbl[k]);
    while (stim_rows.size() < NumDirected + RandomItems) add_random_run();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < stim_rows.size(); i++) begin
      idle_off = ((i / 64) % 3 == 2) || (i + QuietTail >= stim_rows.size());
      if (i == NumDirected || i == MidPauseAt) begin
        // hold off until every owed byte has left
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (decoded_q.size() != 0) @(posedge clk_i);
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 11);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= stim_rows[i].item;
      do @(posedge clk_i); while (in_stall_o);
    end
    in_valid_i <= 1'b0;

    // drain
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    fail_cnt += decoded_q.size();
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
